@@ rtl/biquad_filter_bank_spectrum_core_macros.svh @@
// assertion macros for the biquad filter bank spectrum core
// used by the port checker, no other dependencies
`ifndef BIQUAD_FILTER_BANK_SPECTRUM_CORE_MACROS_SVH
`define BIQUAD_FILTER_BANK_SPECTRUM_CORE_MACROS_SVH

// same-cycle implication
`define BQFB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bqfb port check failed");

// next-cycle implication
`define BQFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqfb port check failed");

`endif

@@ rtl/bqfb_pkg.sv @@
// shared types and constants for the biquad filter bank spectrum core
// no dependencies
package bqfb_pkg;

  localparam int SIG_W      = 32;
  localparam int SIG_FRAC   = 24;
  localparam int NUM_TERMS  = 5;
  localparam int ENV_W      = 24;
  localparam int SUM_W      = 40;
  localparam int MW         = SUM_W + 1;
  localparam int BAND_W     = 6;
  localparam int LEVEL_W    = 16;
  localparam int OUT_W      = 24;
  localparam int FC_W       = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ENV_MAX    = 24'hFFFFFF;
  localparam int EPS_Q24    = 17;
  localparam int DB_PER_OCT = 394566;
  localparam int MAX_FRAME_LOG2 = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILT,
    ST_ENV,
    ST_FRAME,
    ST_EMIT_RD,
    ST_EMIT_LOG,
    ST_EMIT_WAIT,
    ST_EMIT_OUT
  } core_state_t;

  typedef enum logic [2:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ,
    LG_CHK,
    LG_SCALE,
    LG_ROUND
  } log_state_t;

endpackage

@@ rtl/biquad_filter_bank_spectrum_core.sv @@
// top level of the constant-q biquad filter bank spectrum analyzer
// depends on bqfb_pkg and bqfb_log2
//
// a coefficient word is taken in idle and the core stays idle; a sample word keeps the
//   core busy through every band and stage, all of it through the one shared multiplier
// at frame end each band goes through read and start, msb search, squaring, scale,
//   round and hand-off before its word, plus any output stall
// reset: synchronous; a clearing pass zeroes all stores, s_tready stays low
//   meanwhile, config writes are always taken
module biquad_filter_bank_spectrum_core import bqfb_pkg::*; #(
  parameter int NUM_BANDS    = 64,
  parameter int NUM_STAGES   = 2,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24,
  localparam int IW = ((SAMPLE_WIDTH + BAND_W + 4 + COEF_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IW-1:0]         s_tdata,   // sample_value, band_select, stage_select,
                                           // term_select, coef_value, zero fill
  input  logic                  s_tuser,   // opcode: 0 sample, 1 coefficient write
  // level words
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // band_index, level_db, zero fill
  output logic                  m_tlast,   // last band of the frame
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NK  = NUM_BANDS * NUM_STAGES;
  localparam int NC  = NK * NUM_TERMS;
  localparam int KW  = $clog2(NK);
  localparam int CW  = $clog2(NC);
  localparam int BW  = $clog2(NUM_BANDS);
  localparam int SGW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int MA  = (COEF_WIDTH > 18) ? COEF_WIDTH : 18;
  localparam int PW  = MA + SIG_W;
  localparam int ACW = PW + 2;
  localparam int CF  = COEF_WIDTH - 4;
  localparam int XSH = SIG_FRAC - (SAMPLE_WIDTH - 1);
  localparam int BS  = SAMPLE_WIDTH;
  localparam int SS  = BS + BAND_W;
  localparam int TS  = SS + 1;
  localparam int CS  = TS + 3;

  // input word fields
  logic signed [SAMPLE_WIDTH-1:0] s_sample;
  logic [BAND_W-1:0]              s_band;
  logic                           s_stage;
  logic [2:0]                     s_term;
  logic signed [COEF_WIDTH-1:0]   s_coef;

  assign s_sample = s_tdata[SAMPLE_WIDTH-1:0];
  assign s_band   = s_tdata[SS-1:BS];
  assign s_stage  = s_tdata[SS];
  assign s_term   = s_tdata[CS-1:TS];
  assign s_coef   = s_tdata[CS+COEF_WIDTH-1:CS];

  // registers
  logic [15:0] attack_coef, release_coef;
  logic [4:0]  frame_length_log2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef       <= 16'd64519;
      release_coef      <= 16'd65127;
      frame_length_log2 <= 5'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_coef       <= cfg_data;
        CFG_RELEASE: release_coef      <= cfg_data;
        CFG_FRAME:   frame_length_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // stores, one read port each with registered data
  logic signed [COEF_WIDTH-1:0] coef_mem [NC];
  logic signed [SIG_W-1:0]      d1_mem   [NK];
  logic signed [SIG_W-1:0]      d2_mem   [NK];
  logic [ENV_W-1:0]             env_mem  [NUM_BANDS];
  logic [SUM_W-1:0]             sum_mem  [NUM_BANDS];

  logic signed [COEF_WIDTH-1:0] coef_q;
  logic signed [SIG_W-1:0]      d1_q, d2_q;
  logic [ENV_W-1:0]             env_q;
  logic [SUM_W-1:0]             sum_q;

  // sequencer state
  core_state_t state, state_next;
  logic [CW-1:0]  clr;
  logic [BW-1:0]  band;
  logic [SGW-1:0] stg;
  logic [2:0]     ph;
  logic [FC_W-1:0] fc;

  // datapath registers
  logic signed [SIG_W-1:0] x0, xin, y;
  logic signed [PW-1:0]    prod, acc_e;
  logic signed [ACW-1:0]   acc1, acc2;
  logic [16:0]             c_reg;

  // level unit
  logic                      log_start, log_done;
  logic signed [LEVEL_W-1:0] log_level;
  logic [MW-1:0]             log_m;

  logic accept, coef_we, clr_done, last_band_now, last_stage, out_free, frame_end;
  logic [KW-1:0]  k;
  logic [CW-1:0]  coef_raddr, coef_waddr;
  logic [2:0]     term_rd;
  logic [4:0]     lsh;
  logic [FC_W-1:0] fc_inc;

  assign accept   = s_tvalid && s_tready;
  assign coef_we  = accept && s_tuser && (int'(s_band) < NUM_BANDS)
                    && (int'(s_stage) < NUM_STAGES) && (int'(s_term) < NUM_TERMS);
  assign coef_waddr = CW'((int'(s_band) * NUM_STAGES + int'(s_stage)) * NUM_TERMS
                          + int'(s_term));
  assign k          = KW'(int'(band) * NUM_STAGES + int'(stg));
  assign term_rd    = (ph > 3'd4) ? 3'd4 : ph;
  assign coef_raddr = CW'(int'(k) * NUM_TERMS + int'(term_rd));
  assign clr_done   = (clr == CW'(NC - 1));
  assign last_band_now = (band == BW'(NUM_BANDS - 1));
  assign last_stage = (stg == SGW'(NUM_STAGES - 1));
  assign out_free   = !m_tvalid || m_tready;

  // frames longer than 2^16 act as 2^16
  assign lsh       = (frame_length_log2 > 5'(MAX_FRAME_LOG2)) ? 5'(MAX_FRAME_LOG2)
                                                               : frame_length_log2;
  assign fc_inc    = fc + 1'b1;
  assign frame_end = (fc_inc >= (FC_W'(1) << lsh));

  // round half up by the coefficient fraction bits
  function automatic logic signed [ACW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [ACW-1:0] t;
    t = ACW'(p) + (ACW'(1) <<< (CF - 1));
    return t >>> CF;
  endfunction

  // clamp to the signed 32 bit signal range
  function automatic logic signed [SIG_W-1:0] sat32(input logic signed [ACW-1:0] v);
    if (!v[ACW-1] && (|v[ACW-2:SIG_W-1]))     return {1'b0, {(SIG_W-1){1'b1}}};
    else if (v[ACW-1] && !(&v[ACW-2:SIG_W-1])) return {1'b1, {(SIG_W-1){1'b0}}};
    else                                       return v[SIG_W-1:0];
  endfunction

  // envelope follower input and weight
  logic [SIG_W:0]       absy;
  logic [ENV_W-1:0]     v;
  logic [16:0]          c_sel;
  logic [PW:0]          ne_full;
  logic [ENV_W-1:0]     ne;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_new;

  assign absy    = y[SIG_W-1] ? (SIG_W+1)'(-(SIG_W+1)'(y)) : (SIG_W+1)'(y);
  assign v       = (absy > (SIG_W+1)'(ENV_MAX)) ? ENV_W'(ENV_MAX) : absy[ENV_W-1:0];
  assign c_sel   = (v > env_q) ? {1'b0, attack_coef} : {1'b0, release_coef};
  assign ne_full = (PW+1)'(unsigned'(acc_e)) + (PW+1)'(unsigned'(prod)) + (PW+1)'(32768);
  assign ne      = (|ne_full[PW:16+ENV_W]) ? ENV_W'(ENV_MAX) : ne_full[16+ENV_W-1:16];
  assign sum_add = (SUM_W+1)'(sum_q) + (SUM_W+1)'(ne);
  assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // shared multiplier operand selection
  logic signed [MA-1:0]    mul_a;
  logic signed [SIG_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_FILT) begin
      mul_a = MA'(coef_q);
      mul_b = (ph <= 3'd3) ? xin : y;
    end else if (state == ST_ENV) begin
      if (ph == 3'd0) begin
        mul_a = $signed(MA'(c_sel));
        mul_b = $signed(SIG_W'(env_q));
      end else begin
        mul_a = $signed(MA'(17'd65536 - c_reg));
        mul_b = $signed(SIG_W'(v));
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    log_start  = 1'b0;
    unique case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && !s_tuser) state_next = ST_FILT;
      end
      ST_FILT:  if (ph == 3'd6 && last_stage) state_next = ST_ENV;
      ST_ENV: begin
        if (ph == 3'd2) state_next = last_band_now ? ST_FRAME : ST_FILT;
      end
      ST_FRAME:    state_next = frame_end ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD:  state_next = ST_EMIT_LOG;
      ST_EMIT_LOG: begin
        log_start  = 1'b1;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: if (log_done) state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free) state_next = last_band_now ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // counters and frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      band <= '0;
      stg  <= '0;
      ph   <= '0;
      fc   <= '0;
    end else begin
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          band <= '0;
          stg  <= '0;
          ph   <= '0;
        end
        ST_FILT: begin
          if (ph == 3'd6) begin
            ph <= '0;
            if (!last_stage) stg <= stg + 1'b1;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_ENV: begin
          if (ph == 3'd2) begin
            ph  <= '0;
            stg <= '0;
            if (!last_band_now) band <= band + 1'b1;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        ST_FRAME: begin
          band <= '0;
          fc   <= frame_end ? '0 : fc_inc;
        end
        ST_EMIT_OUT: if (out_free && !last_band_now) band <= band + 1'b1;
        default: ;
      endcase
    end
  end

  // filter and envelope datapath, one product per cycle
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
    if (accept && !s_tuser) begin
      x0  <= SIG_W'(s_sample) <<< XSH;
      xin <= SIG_W'(s_sample) <<< XSH;
    end
    if (state == ST_FILT) begin
      // ph1 b0*x, ph2 b1*x, ph3 b2*x, ph4 a1*y, ph5 a2*y enter the product register
      case (ph)
        3'd2: y    <= sat32(rnd(prod) + ACW'(d1_q));
        3'd3: acc1 <= rnd(prod) + ACW'(d2_q);
        3'd4: acc2 <= rnd(prod);
        3'd6: xin  <= y;
        default: ;
      endcase
    end
    if (state == ST_ENV) begin
      if (ph == 3'd0) c_reg <= c_sel;
      if (ph == 3'd1) acc_e <= prod;
      if (ph == 3'd2) xin   <= x0;
    end
  end

  // store writes and reads
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      coef_mem[clr] <= '0;
      if (int'(clr) < NK) begin
        d1_mem[clr[KW-1:0]] <= '0;
        d2_mem[clr[KW-1:0]] <= '0;
      end
      if (int'(clr) < NUM_BANDS) begin
        env_mem[clr[BW-1:0]] <= '0;
        sum_mem[clr[BW-1:0]] <= '0;
      end
    end else begin
      if (coef_we) coef_mem[coef_waddr] <= s_coef;
      if (state == ST_FILT && ph == 3'd5) d1_mem[k] <= sat32(acc1 - rnd(prod));
      if (state == ST_FILT && ph == 3'd6) d2_mem[k] <= sat32(acc2 - rnd(prod));
      if (state == ST_ENV && ph == 3'd2) begin
        env_mem[band] <= ne;
        sum_mem[band] <= sum_new;
      end
      if (state == ST_EMIT_OUT && out_free) sum_mem[band] <= '0;
    end
    coef_q <= coef_mem[coef_raddr];
    d1_q   <= d1_mem[k];
    d2_q   <= d2_mem[k];
    env_q  <= env_mem[band];
    sum_q  <= sum_mem[band];
  end

  // mean plus 1e-6 in q0.24
  assign log_m = MW'(sum_q >> lsh) + MW'(EPS_Q24);

  bqfb_log2 u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .m     (log_m),
    .done  (log_done),
    .level (log_level)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_OUT && out_free) begin
      m_tdata <= {{(OUT_W-BAND_W-LEVEL_W){1'b0}}, log_level, BAND_W'(band)};
      m_tlast <= last_band_now;
    end
  end

endmodule

@@ rtl/bqfb_log2.sv @@
// iterative level unit: msb search, squaring log2 and scale to Q7.8 dB
// depends on bqfb_pkg
module bqfb_log2 import bqfb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [MW-1:0]             m,
  output logic                      done,
  output logic signed [LEVEL_W-1:0] level
);

  log_state_t lstate, lstate_next;
  logic [MW-1:0]      w;
  logic [5:0]         e;
  logic [30:0]        x;
  logic [61:0]        sq;
  logic [15:0]        frac;
  logic [3:0]         cnt;
  logic signed [43:0] prodl;
  logic [31:0]        t;
  logic signed [22:0] lval;
  logic signed [43:0] rsum;
  logic signed [19:0] rsh;

  assign t    = sq[61:30];
  assign lval = $signed({1'b0, e, frac}) - 23'sd1572864;
  assign rsum = prodl + (44'sd1 <<< 23);
  assign rsh  = 20'(rsum >>> 24);

  always_ff @(posedge clk) begin
    if (rst) lstate <= LG_IDLE;
    else     lstate <= lstate_next;
  end

  always_comb begin
    lstate_next = lstate;
    unique case (lstate)
      LG_IDLE:  if (start) lstate_next = LG_NORM;
      LG_NORM:  if (w[MW-1]) lstate_next = LG_SQ;
      LG_SQ:    lstate_next = LG_CHK;
      LG_CHK:   lstate_next = (cnt == 4'd15) ? LG_SCALE : LG_SQ;
      LG_SCALE: lstate_next = LG_ROUND;
      LG_ROUND: lstate_next = LG_IDLE;
      default:  lstate_next = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (start) begin
      done <= 1'b0;
    end else if (lstate == LG_ROUND) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (lstate)
      LG_IDLE: begin
        if (start) begin
          w    <= m;
          e    <= 6'(MW - 1);
          frac <= '0;
          cnt  <= '0;
        end
      end
      LG_NORM: begin
        // shift up until the msb lands on top
        if (w[MW-1]) begin
          x <= w[MW-1:MW-31];
        end else begin
          w <= w << 1;
          e <= e - 6'd1;
        end
      end
      LG_SQ: sq <= 62'(x) * 62'(x);
      LG_CHK: begin
        frac <= {frac[14:0], t[31]};
        x    <= t[31] ? t[31:1] : t[30:0];
        cnt  <= cnt + 4'd1;
      end
      LG_SCALE: prodl <= 44'(lval) * 44'sd394566;
      LG_ROUND: begin
        if (rsh > 20'sd32767)       level <= 16'sh7fff;
        else if (rsh < -20'sd32768) level <= 16'sh8000;
        else                        level <= rsh[15:0];
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bqfb_checker.sv @@
// port checker for the biquad filter bank spectrum core, bound to the top level
// depends on bqfb_pkg and the macros header
`include "biquad_filter_bank_spectrum_core_macros.svh"

module bqfb_checker import bqfb_pkg::*; #(
  parameter int NUM_BANDS = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // a waiting level word holds
  `BQFB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `BQFB_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // the last word of a frame carries the top band
  `BQFB_ASSERT_SAME(a_last_band, clk, rst, m_tvalid && m_tlast, m_tdata[BAND_W-1:0] == BAND_W'(NUM_BANDS - 1))
  // a sample keeps the core busy, a coefficient write does not
  `BQFB_ASSERT_NEXT(a_sample_busy, clk, rst, s_tvalid && s_tready && !s_tuser, !s_tready)
  `BQFB_ASSERT_NEXT(a_coef_quick, clk, rst, s_tvalid && s_tready && s_tuser, s_tready)

endmodule

bind biquad_filter_bank_spectrum_core bqfb_checker #(.NUM_BANDS(NUM_BANDS)) u_bqfb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ tb/testbench.sv @@
// self-checking testbench for biquad_filter_bank_spectrum_core
// depends on bqfb_pkg and the core rtl; predicts band levels with its own filter bank model
`timescale 1ns / 1ps

module testbench;
  import bqfb_pkg::*;

  localparam int BANDS  = 64;
  localparam int STAGES = 2;
  localparam int DW     = 56;
  localparam int SETTLE = 1200;        // one sample word plus margin
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 8000;

  localparam bit OP_SAMPLE = 1'b0;
  localparam bit OP_COEF   = 1'b1;
  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;
  localparam logic [2:0] TERM_BAD_LO = 3'd5;
  localparam logic [2:0] TERM_BAD_HI = 3'd7;

  typedef struct {
    bit                 op;
    logic signed [15:0] smp;
    logic [5:0]         band;
    logic               stage;
    logic [2:0]         term;
    logic signed [23:0] coef;
  } word_t;

  typedef struct {
    logic [5:0]  band;
    logic [15:0] level;
    logic        last;
  } level_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  biquad_filter_bank_spectrum_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state of the filter bank
  longint dly1 [BANDS*STAGES];
  longint dly2 [BANDS*STAGES];
  longint coefs [BANDS*STAGES*NUM_TERMS];
  longint unsigned env_lvl [BANDS];
  longint unsigned band_acc [BANDS];
  int unsigned frame_cnt;
  int unsigned attack_c, release_c, frame_log2;

  word_t  pending_words [$];
  level_t expected_levels [$];
  int errors = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // coefficient product back to signal format, round half up
  function automatic longint coef_mul(longint c, longint x);
    return (c * x + (64'sd1 <<< 19)) >>> 20;
  endfunction

  // 20*log10 of the frame mean in q7.8 dB
  function automatic logic [15:0] band_level_db(longint unsigned acc, int unsigned l);
    longint unsigned m, x, frac;
    int e;
    longint lg, lv;
    m = (acc >> l) + EPS_Q24;
    e = 0;
    frac = 0;
    while ((m >> (e + 1)) != 0) e++;
    x = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    lg = longint'((longint'(e) << 16) | frac) - (64'sd24 <<< 16);
    lv = (lg * DB_PER_OCT + (64'sd1 <<< 23)) >>> 24;
    if (lv > 32767) lv = 32767;
    if (lv < -32768) lv = -32768;
    return lv[15:0];
  endfunction

  // advance the model by one accepted word, queue the levels it produces
  function automatic void filter_bank_step(word_t w);
    longint x0, y, xi, av;
    longint unsigned v, ev, c, ne;
    int k;
    int unsigned l;
    level_t r;
    if (w.op == OP_COEF) begin
      if (w.term < NUM_TERMS)
        coefs[(int'(w.band) * STAGES + int'(w.stage)) * NUM_TERMS + int'(w.term)] =
          longint'(w.coef);
      return;
    end
    x0 = longint'(w.smp) * 512;
    for (int b = 0; b < BANDS; b++) begin
      y = x0;
      for (int s = 0; s < STAGES; s++) begin
        k = b * STAGES + s;
        xi = y;
        y = sat32(coef_mul(coefs[k*NUM_TERMS+TERM_B0], xi) + dly1[k]);
        dly1[k] = sat32(coef_mul(coefs[k*NUM_TERMS+TERM_B1], xi)
                        - coef_mul(coefs[k*NUM_TERMS+TERM_A1], y) + dly2[k]);
        dly2[k] = sat32(coef_mul(coefs[k*NUM_TERMS+TERM_B2], xi)
                        - coef_mul(coefs[k*NUM_TERMS+TERM_A2], y));
      end
      av = (y < 0) ? -y : y;
      v = (av > ENV_MAX) ? ENV_MAX : av;
      ev = env_lvl[b];
      c = (v > ev) ? attack_c : release_c;
      ne = (c * ev + (65536 - c) * v + 32768) >> 16;
      if (ne > ENV_MAX) ne = ENV_MAX;
      env_lvl[b] = ne;
      band_acc[b] = band_acc[b] + ne;
      if (band_acc[b] > 64'hFF_FFFF_FFFF) band_acc[b] = 64'hFF_FFFF_FFFF;
    end
    l = (frame_log2 > MAX_FRAME_LOG2) ? MAX_FRAME_LOG2 : frame_log2;
    frame_cnt = (frame_cnt + 1) & 32'h1FFFF;
    if (frame_cnt < (32'd1 << l)) return;
    for (int b = 0; b < BANDS; b++) begin
      r.band = b[5:0];
      r.level = band_level_db(band_acc[b], l);
      r.last = (b == BANDS - 1);
      expected_levels.push_back(r);
      band_acc[b] = 0;
    end
    frame_cnt = 0;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------
  // input driver: offers queued words, predicts on acceptance
  // ---------------------------------------------------------------
  word_t cur_word;
  bit offering = 0;
  int tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        filter_bank_step(cur_word);
        offering = 0;
        tx_gap = next_gap();
      end
      if (!offering) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          offering = 1;
        end
      end
      s_tvalid <= offering;
      // tdata: sample_value, band_select, stage_select, term_select, coef_value, zero fill
      s_tdata <= {6'd0, cur_word.coef, cur_word.term, cur_word.stage, cur_word.band,
                  cur_word.smp};
      s_tuser <= cur_word.op;
    end
  end

  // ---------------------------------------------------------------
  // long receiver hold-off, counted here, started once by the sequence
  // ---------------------------------------------------------------
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    else if (hold_go && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // level monitor: random ready, compares against the oldest prediction
  // ---------------------------------------------------------------
  int rx_gap = 0;

  always @(posedge clk) begin
    level_t want;
    logic [5:0] got_band;
    logic [15:0] got_level;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_band = m_tdata[5:0];
        got_level = m_tdata[21:6];
        if (expected_levels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected level word: band %0d level %0d last %0b",
                     got_band, $signed(got_level), m_tlast);
        end else begin
          want = expected_levels.pop_front();
          if (got_band !== want.band || got_level !== want.level || m_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("level mismatch: expected band %0d level %0d last %0b, got %0d %0d %0b",
                       want.band, $signed(want.level), want.last,
                       got_band, $signed(got_level), m_tlast);
          end
        end
        rx_gap = next_gap();
      end
      if (hold_cnt != 0 || rx_gap != 0) begin
        m_tready <= 1'b0;
        if (rx_gap != 0) rx_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // watchdog: ends the run when nothing moves for too long
  // ---------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // ---------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------
  function automatic word_t sample_word(logic signed [15:0] v);
    word_t w;
    w.op = OP_SAMPLE;
    w.smp = v;
    w.band = 6'($urandom);
    w.stage = 1'($urandom);
    w.term = 3'($urandom);
    w.coef = 24'($urandom);
    return w;
  endfunction

  function automatic word_t coef_word(logic [5:0] band, logic stage, logic [2:0] term,
                                      logic signed [23:0] value);
    word_t w;
    w.op = OP_COEF;
    w.smp = 16'($urandom);
    w.band = band;
    w.stage = stage;
    w.term = term;
    w.coef = value;
    return w;
  endfunction

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK:  attack_c = 32'(val);
      CFG_RELEASE: release_c = 32'(val);
      CFG_FRAME:   frame_log2 = 32'(val[4:0]);
      default: ;
    endcase
  endtask

  // all words sent, all levels back, then let the last sample word drain
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || offering || expected_levels.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random mix: mostly samples, coefficient writes with random content
  task automatic queue_random(int n);
    logic [2:0] term;
    logic signed [23:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 19) == 0)
          pending_words.push_back(sample_word($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000));
        else
          pending_words.push_back(sample_word(16'($urandom)));
      end else begin
        term = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(TERM_BAD_LO, TERM_BAD_HI))
                                           : 3'($urandom_range(TERM_B0, TERM_A2));
        // mostly within +-1.0 so cascades stay out of saturation some of the time
        c = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                        : 24'($signed($urandom_range(0, 2097152)) - 1048576);
        pending_words.push_back(coef_word(6'($urandom), 1'($urandom), term, c));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < BANDS*STAGES; i++) begin
      dly1[i] = 0;
      dly2[i] = 0;
    end
    for (int i = 0; i < BANDS*STAGES*NUM_TERMS; i++) coefs[i] = 0;
    for (int i = 0; i < BANDS; i++) begin
      env_lvl[i] = 0;
      band_acc[i] = 0;
    end
    frame_cnt = 0;
    attack_c = 64519;
    release_c = 65127;
    frame_log2 = 10;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: one frame per sample, fastest attack, slowest release
    reg_write(CFG_ATTACK, 16'd0);
    reg_write(CFG_RELEASE, 16'hFFFF);
    reg_write(CFG_FRAME, 16'd0);
    // unloaded coefficients first, every band near the floor
    pending_words.push_back(sample_word(16'sh7FFF));
    pending_words.push_back(sample_word(16'sh8000));
    pending_words.push_back(coef_word(6'd0, 1'b0, TERM_B0, 24'sh7FFFFF));
    pending_words.push_back(coef_word(6'd0, 1'b1, TERM_B0, 24'sh800000));
    pending_words.push_back(coef_word(6'd63, 1'b0, TERM_B0, 24'sh100000));
    pending_words.push_back(coef_word(6'd63, 1'b1, TERM_B0, 24'sh100000));
    pending_words.push_back(coef_word(6'd63, 1'b1, TERM_A2, 24'sh040000));
    pending_words.push_back(coef_word(6'd5, 1'b0, TERM_B0, 24'sh020000));
    pending_words.push_back(coef_word(6'd5, 1'b0, TERM_B1, 24'sh000000));
    pending_words.push_back(coef_word(6'd5, 1'b0, TERM_B2, 24'shFE0000));
    pending_words.push_back(coef_word(6'd5, 1'b0, TERM_A1, 24'shE40000));
    pending_words.push_back(coef_word(6'd5, 1'b0, TERM_A2, 24'h0F0000));
    pending_words.push_back(coef_word(6'd5, 1'b1, TERM_B0, 24'sh100000));
    // out-of-range terms must be dropped
    pending_words.push_back(coef_word(6'd5, 1'b1, TERM_BAD_LO, 24'sh7FFFFF));
    pending_words.push_back(coef_word(6'd0, 1'b0, TERM_BAD_HI, 24'sh800000));
    pending_words.push_back(sample_word(16'sh7FFF));
    pending_words.push_back(sample_word(16'sh8000));
    pending_words.push_back(sample_word(16'sh0000));
    pending_words.push_back(sample_word(16'sh0001));
    pending_words.push_back(sample_word(16'shFFFF));
    pending_words.push_back(sample_word(16'sh5555));
    pending_words.push_back(sample_word(16'shAAAA));
    wait_quiet();

    // opposite smoothing extremes, four-sample frames, receiver held off at the start
    reg_write(CFG_ATTACK, 16'hFFFF);
    reg_write(CFG_RELEASE, 16'd0);
    reg_write(CFG_FRAME, 16'd2);
    queue_random(100);
    hold_go = 1;
    wait_quiet();

    // frame length beyond the cap, then lowered mid-frame
    reg_write(CFG_FRAME, 16'd31);
    for (int i = 0; i < 3; i++) pending_words.push_back(sample_word(16'($urandom)));
    wait_quiet();
    reg_write(CFG_FRAME, 16'd1);
    queue_random(90);
    wait_quiet();

    // default-like smoothing with random weights, eight-sample frames
    reg_write(CFG_ATTACK, 16'($urandom));
    reg_write(CFG_RELEASE, 16'($urandom));
    reg_write(CFG_FRAME, 16'd3);
    queue_random(100);
    wait_quiet();

    if (errors == 0 && expected_levels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
